// ===== sv/bmhq_pkg.sv =====
`timescale 1ns / 1ps
package bmhq_pkg;

   localparam int CAPACITY_DEF     = 256;
   localparam int KEY_BITS_DEF     = 32;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_PEEK   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UP_READ,
      ST_UP_CMP,
      ST_ROOT_READ,
      ST_ROOT_LOAD,
      ST_LAST_LOAD,
      ST_DN_READ_L,
      ST_DN_READ_R,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic write_new;
      logic up_read;
      logic up_step;
      logic root_read;
      logic root_load;
      logic take_last;
      logic last_load;
      logic dn_read_l;
      logic dn_read_r;
      logic dn_step;
      logic set_full;
      logic set_empty;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       is_full;
      logic       is_empty;
      logic       up_more;
      logic       up_go;
      logic       dn_more;
      logic       dn_has_l;
   } sts_type;

endpackage

// ===== sv/bmhq_ctrl.sv =====
`timescale 1ns / 1ps
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.func)
               FUNC_INSERT: state_in = sts.is_full ? ST_DONE : ST_UP_READ;
               FUNC_REMOVE, FUNC_PEEK: state_in = sts.is_empty ? ST_DONE : ST_ROOT_READ;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_UP_READ:   state_in = sts.up_more ? ST_UP_CMP : ST_DONE;
         ST_UP_CMP:    state_in = sts.up_go ? ST_UP_READ : ST_DONE;
         ST_ROOT_READ: state_in = ST_ROOT_LOAD;
         ST_ROOT_LOAD: state_in = (sts.func == FUNC_REMOVE) ? ST_LAST_LOAD : ST_DONE;
         ST_LAST_LOAD: state_in = ST_DN_READ_L;
         ST_DN_READ_L: state_in = sts.dn_has_l ? ST_DN_READ_R : ST_DONE;
         ST_DN_READ_R: state_in = ST_DN_CMP;
         ST_DN_CMP:    state_in = sts.dn_more ? ST_DN_READ_L : ST_DONE;
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_DISPATCH: begin
            if (sts.func == FUNC_INSERT && !sts.is_full) cmd.write_new = 1'b1;
            if (sts.func == FUNC_INSERT && sts.is_full) cmd.set_full = 1'b1;
            if ((sts.func == FUNC_REMOVE || sts.func == FUNC_PEEK) && sts.is_empty)
               cmd.set_empty = 1'b1;
         end
         ST_UP_READ:   cmd.up_read   = 1'b1;
         ST_UP_CMP:    cmd.up_step   = 1'b1;
         ST_ROOT_READ: cmd.root_read = 1'b1;
         ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            cmd.take_last = (sts.func == FUNC_REMOVE);
         end
         ST_LAST_LOAD: cmd.last_load = 1'b1;
         ST_DN_READ_L: cmd.dn_read_l = 1'b1;
         ST_DN_READ_R: cmd.dn_read_r = 1'b1;
         ST_DN_CMP:    cmd.dn_step   = 1'b1;
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/bmhq_dp.sv =====
`timescale 1ns / 1ps
module bmhq_dp
   import bmhq_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_payload,
   output logic [8:0]  rsp_count,
   output logic        rsp_is_empty,
   output logic        rsp_is_full
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_BITS + PAYLOAD_BITS;
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_ff;

   logic [CW-1:0]       count_ff, count_in;
   logic [1:0]          func_ff;
   logic [1:0]          status_ff;
   logic [EW-1:0]       cur_ff, cur_in;
   logic [EW-1:0]       lch_ff;
   logic [AW:0]         pos_ff, pos_in;
   logic [31:0]         okey_ff, opay_ff;
   logic                we;
   logic [AW-1:0]       waddr, raddr;
   logic [EW-1:0]       wdata;

   logic [AW:0] parent, lidx, ridx;
   logic [KEY_BITS-1:0] cur_key, rd_key, l_key;
   logic up_go, r_ok, l_ok;

   assign parent  = (pos_ff - 1'b1) >> 1;
   assign lidx    = {pos_ff[AW-1:0], 1'b1};
   assign ridx    = lidx + 1'b1;
   assign cur_key = cur_ff[EW-1:PAYLOAD_BITS];
   assign rd_key  = rd_ff[EW-1:PAYLOAD_BITS];
   assign l_key   = lch_ff[EW-1:PAYLOAD_BITS];
   assign up_go   = rd_key > cur_key;
   assign l_ok    = (CW'(lidx) < count_ff) && (l_key < cur_key);
   assign r_ok    = (CW'(ridx) < count_ff) &&
                    (rd_key < (l_ok ? l_key : cur_key));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      we     = 1'b0;
      waddr  = pos_ff[AW-1:0];
      wdata  = cur_ff;
      raddr  = parent[AW-1:0];
      pos_in = pos_ff;
      cur_in = cur_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         cur_in = {req_key[KEY_BITS-1:0], req_payload[PAYLOAD_BITS-1:0]};
      end
      if (cmd.write_new) begin
         we       = 1'b1;
         waddr    = count_ff[AW-1:0];
         pos_in   = (AW+1)'(count_ff);
         count_in = count_ff + 1'b1;
      end
      // hole reached the root
      if (cmd.up_read && !sts.up_more) we = 1'b1;
      if (cmd.up_step) begin
         we = 1'b1;
         if (up_go) begin
            wdata  = rd_ff;
            pos_in = parent;
         end
      end
      if (cmd.root_read) raddr = '0;
      if (cmd.take_last) begin
         raddr    = AW'(count_ff - 1'b1);
         count_in = count_ff - 1'b1;
         pos_in   = '0;
      end
      if (cmd.last_load) cur_in = rd_ff;
      if (cmd.dn_read_l) raddr = lidx[AW-1:0];
      if (cmd.dn_read_r) raddr = ridx[AW-1:0];
      if (cmd.dn_step) begin
         we = 1'b1;
         if (r_ok) begin
            wdata  = rd_ff;
            pos_in = ridx;
         end else if (l_ok) begin
            wdata  = lch_ff;
            pos_in = lidx;
         end
      end
      if (cmd.dn_read_l && !sts.dn_has_l) we = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.dn_read_r) lch_ff <= rd_ff;
      if (cmd.load_req) begin
         func_ff   <= req_func;
         status_ff <= STATUS_OK;
         okey_ff   <= '0;
         opay_ff   <= '0;
      end
      if (cmd.set_full)  status_ff <= STATUS_FULL;
      if (cmd.set_empty) status_ff <= STATUS_EMPTY;
      if (cmd.root_load) begin
         okey_ff <= 32'(rd_ff[EW-1:PAYLOAD_BITS]);
         opay_ff <= 32'(rd_ff[PAYLOAD_BITS-1:0]);
      end
   end

   assign sts.func     = func_ff;
   assign sts.is_full  = (count_ff >= CAP);
   assign sts.is_empty = (count_ff == '0);
   assign sts.up_more  = (pos_ff != '0);
   assign sts.up_go    = up_go;
   assign sts.dn_has_l = (CW'(lidx) < count_ff) && (lidx <= (AW+1)'(CAPACITY - 1));
   assign sts.dn_more  = r_ok || l_ok;

   assign rsp_status      = status_ff;
   assign rsp_out_key     = okey_ff;
   assign rsp_out_payload = opay_ff;
   assign rsp_count       = 9'(count_ff);
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_is_full     = (count_ff == CAP);

endmodule

// ===== sv/binary_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// Binary min-heap priority queue. func 0 inserts (key, payload), 1 removes the
// minimum, 2 peeks it, 3 does nothing; each request yields one response with
// status, count and empty/full flags. Entries sit in a RAM with one write port
// and one registered read port; the sift walks one heap level per read and
// compare step going up (UP_READ, UP_CMP) and per left read, right read and
// compare step going down (DN_READ_L, DN_READ_R, DN_CMP). A rejected or unused
// request goes from dispatch straight to the response. A new request is taken
// in the cycle after the response transaction. One transaction is in flight at
// a time.
module binary_min_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_payload,
   output logic [8:0]  rsp_count,
   output logic        rsp_is_empty,
   output logic        rsp_is_full
);

   cmd_type cmd;
   sts_type sts;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmhq_dp #(
      .CAPACITY     (CAPACITY),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

// ===== sim/heap_queue_checker.sv =====
`timescale 1ns / 1ps
module heap_queue_checker
   import bmhq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_out_key,
   input  logic [31:0] rsp_out_payload,
   input  logic [8:0]  rsp_count,
   input  logic        rsp_is_empty,
   input  logic        rsp_is_full,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_key;
      logic [31:0] out_payload;
      logic [8:0]  count;
      logic        is_empty;
      logic        is_full;
   } heap_result_type;

   logic [31:0]  keys [CAPACITY_DEF];
   logic [31:0]  pays [CAPACITY_DEF];
   int           stored;
   heap_result_type expected_results[$];

   function automatic void swap_entries(int a, int b);
      logic [31:0] t;
      t = keys[a]; keys[a] = keys[b]; keys[b] = t;
      t = pays[a]; pays[a] = pays[b]; pays[b] = t;
   endfunction

   function automatic heap_result_type heap_apply(logic [1:0] f, logic [31:0] k,
                                                  logic [31:0] p);
      heap_result_type r;
      int pos, up, l, rr, best;
      r = '0;
      if (f == FUNC_INSERT) begin
         if (stored >= CAPACITY_DEF) begin
            r.status = STATUS_FULL;
         end else begin
            keys[stored] = k;
            pays[stored] = p;
            pos = stored;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(keys[up] > keys[pos])) break;
               swap_entries(up, pos);
               pos = up;
            end
            stored++;
         end
      end else if (f == FUNC_REMOVE || f == FUNC_PEEK) begin
         if (stored == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.out_key = keys[0];
            r.out_payload = pays[0];
            if (f == FUNC_REMOVE) begin
               stored--;
               keys[0] = keys[stored];
               pays[0] = pays[stored];
               pos = 0;
               while (pos < stored) begin
                  l = 2 * pos + 1;
                  rr = 2 * pos + 2;
                  best = pos;
                  if (l < stored && keys[l] < keys[best]) best = l;
                  if (rr < stored && keys[rr] < keys[best]) best = rr;
                  if (best == pos) break;
                  swap_entries(pos, best);
                  pos = best;
               end
            end
         end
      end
      r.count = stored[8:0];
      r.is_empty = (stored == 0);
      r.is_full = (stored == CAPACITY_DEF);
      return r;
   endfunction

   always @(posedge clock) begin
      heap_result_type e;
      if (reset) begin
         stored = 0;
         expected_results.delete();
         fail_count <= 0;
         pending <= 0;
         rsp_seen <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(heap_apply(req_func, req_key, req_payload));
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_results.size() == 0) begin
               $error("response with no transaction outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (e.status !== rsp_status || e.out_key !== rsp_out_key ||
                   e.out_payload !== rsp_out_payload || e.count !== rsp_count ||
                   e.is_empty !== rsp_is_empty || e.is_full !== rsp_is_full) begin
                  if (e.status !== rsp_status)
                     $error("status exp %0d got %0d", e.status, rsp_status);
                  if (e.out_key !== rsp_out_key)
                     $error("out_key exp %h got %h", e.out_key, rsp_out_key);
                  if (e.out_payload !== rsp_out_payload)
                     $error("out_payload exp %h got %h", e.out_payload, rsp_out_payload);
                  if (e.count !== rsp_count)
                     $error("count exp %0d got %0d", e.count, rsp_count);
                  if (e.is_empty !== rsp_is_empty)
                     $error("is_empty exp %0d got %0d", e.is_empty, rsp_is_empty);
                  if (e.is_full !== rsp_is_full)
                     $error("is_full exp %0d got %0d", e.is_full, rsp_is_full);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_results.size();
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import bmhq_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_INSERT;
   logic [31:0] req_key = '0;
   logic [31:0] req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_payload;
   logic [8:0]  rsp_count;
   logic        rsp_is_empty;
   logic        rsp_is_full;
   int          fail_count, pending, rsp_seen;
   int          level;
   bit          quiet_tail = 0;
   int          ops_sent [4];

   binary_min_heap_queue_top DUT (.*);
   heap_queue_checker checker_i (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      int n;
      if (!quiet_tail && !reset && $urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 13);
         rsp_stall <= 1;
         repeat (n) @(posedge clock);
      end
      rsp_stall <= 0;
   end

   task automatic send_op(logic [1:0] f, logic [31:0] k, logic [31:0] p);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_key <= k;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      ops_sent[f]++;
      if (f == FUNC_INSERT && level < CAPACITY_DEF) level++;
      if (f == FUNC_REMOVE && level > 0) level--;
   endtask

   task automatic random_op(int bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) send_op(FUNC_NONE, $urandom, $urandom);
      else if (r < bias) send_op(FUNC_INSERT,
                                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom,
                                 $urandom);
      else if (r < bias + 12) send_op(FUNC_PEEK, $urandom, $urandom);
      else send_op(FUNC_REMOVE, $urandom, $urandom);
   endtask

   initial begin
      int cycles;
      level = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_op(FUNC_REMOVE, '0, '0);
      send_op(FUNC_PEEK, '1, '1);
      send_op(FUNC_INSERT, '1, '1);
      send_op(FUNC_INSERT, '0, '0);
      send_op(FUNC_INSERT, 32'd5, 32'hA5A5A5A5);
      send_op(FUNC_INSERT, 32'd5, 32'h5A5A5A5A);
      send_op(FUNC_INSERT, 32'd5, 32'h12345678);
      send_op(FUNC_NONE, '1, '1);
      send_op(FUNC_PEEK, '0, '0);
      repeat (5) send_op(FUNC_REMOVE, '0, '0);
      send_op(FUNC_REMOVE, '0, '0);
      // fill to capacity, overflow, then drain to empty
      while (level < CAPACITY_DEF) send_op(FUNC_INSERT, $urandom, $urandom);
      send_op(FUNC_INSERT, '1, '1);
      send_op(FUNC_PEEK, '0, '0);
      while (level > 0) send_op(FUNC_REMOVE, $urandom, $urandom);
      repeat (80) random_op(level < 40 ? 70 : 45);
      repeat (80) random_op(level > 10 ? 30 : 60);
      quiet_tail = 1;
      repeat (60) random_op(50);
      req_valid <= 0;
      cycles = 0;
      while ((pending != 0 || rsp_seen < 1) && cycles < 100000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (60) @(posedge clock);
      $display("Sent %0d inserts, %0d removes, %0d peeks, %0d unused opcodes",
               ops_sent[FUNC_INSERT], ops_sent[FUNC_REMOVE], ops_sent[FUNC_PEEK],
               ops_sent[FUNC_NONE]);
      $display("Covered empty and full rejects and a complete fill and drain");
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== binary_min_heap_queue_top.f =====
sv/bmhq_pkg.sv
sv/bmhq_ctrl.sv
sv/bmhq_dp.sv
sv/binary_min_heap_queue_top.sv
sim/heap_queue_checker.sv
sim/tb.sv
